### rtl/fau_pkg.sv
// Shared types and constants for the fraction ALU.
package fau_pkg;
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;
   localparam int CMD_W = 3;
   localparam int STS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;

   localparam logic [STS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STS_ZERODEN = 2'd1;
   localparam logic [STS_W-1:0] STS_DIVZERO = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_SUM,
      ST_GCD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic prod;
      logic sum;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic gcd_done;
      logic div_done;
   } sts_type;
endpackage

### rtl/fau_ctrl.sv
// Sequencer for the fraction ALU.
module fau_ctrl
   import fau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_PROD;
         ST_PROD: state_in = sts.err ? ST_OUT : ST_SUM;
         ST_SUM:  state_in = ST_GCD;
         ST_GCD:  if (sts.gcd_done) state_in = ST_DIV;
         ST_DIV:  if (sts.div_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_PROD: cmd.prod = 1'b1;
         ST_SUM:  cmd.sum = 1'b1;
         ST_GCD: begin
            cmd.gcd_step  = !sts.gcd_done;
            cmd.div_start = sts.gcd_done;
         end
         ST_DIV:  cmd.div_step = !sts.div_done;
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
endmodule

### rtl/fau_dp.sv
// Datapath for the fraction ALU: products, sum, gcd and division by gcd.
module fau_dp
   import fau_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic              clock,
   input  logic [CMD_W-1:0]  command,
   input  logic [WIDTH-1:0]  a_num,
   input  logic [WIDTH-1:0]  a_den,
   input  logic [WIDTH-1:0]  b_num,
   input  logic [WIDTH-1:0]  b_den,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic [NUM_W-1:0]  res_num,
   output logic [DEN_W-1:0]  res_den,
   output logic [STS_W-1:0]  status
);
   localparam int PW  = 2 * WIDTH;
   localparam int MW  = PW + 1;
   localparam int CW  = $clog2(MW + 1);

   logic [CMD_W-1:0] cmd_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic             ad_s_ff, bn_s_ff;
   logic [PW-1:0]    p1_ff, p2_ff, pd_ff;
   logic             p1_s_ff, p2_s_ff, pd_s_ff;
   logic [MW-1:0]    nm_ff, dm_ff, gx_ff, gy_ff;
   logic [CW-1:0]    k_ff;
   logic             neg_ff;
   logic [STS_W-1:0] sts_ff;
   logic [MW-1:0]    q_ff, rem_ff, dvd_ff;
   logic [MW-1:0]    qn_ff;
   logic             phase_ff;
   logic [CW-1:0]    cnt_ff;
   logic [NUM_W-1:0] rn_ff;
   logic [DEN_W-1:0] rd_ff;
   logic [STS_W-1:0] rs_ff;

   logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
   logic             uses_b, bn_neg_eff;
   logic [STS_W-1:0] sts_calc;
   logic             p2_neg;
   logic [MW-1:0]    sum_mag;
   logic             sum_neg;
   logic [MW:0]      rtry;
   logic [MW-1:0]    rsh;
   logic [MW-1:0]    gx_sub, gy_sub;

   function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
      mag = v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign an_m = mag(an_ff);
   assign ad_m = mag(ad_ff);
   assign bn_m = mag(bn_ff);
   assign bd_m = mag(bd_ff);
   assign uses_b = (cmd_ff <= CMD_DIV);
   assign bn_neg_eff = (cmd_ff == CMD_SUB) ? !bn_s_ff : bn_s_ff;

   always_comb begin
      priority if (ad_ff == '0 || (uses_b && bd_ff == '0)) sts_calc = STS_ZERODEN;
      else if (cmd_ff == CMD_DIV && bn_ff == '0)          sts_calc = STS_DIVZERO;
      else                                                  sts_calc = STS_OK;
   end

   always_comb begin
      p2_neg = (cmd_ff == CMD_SUB) ? (bn_neg_eff ^ ad_s_ff) : p2_s_ff;
      priority if (p2_neg == p1_s_ff || cmd_ff > CMD_SUB) begin
         sum_mag = MW'(p1_ff) + MW'(p2_ff);
         sum_neg = p1_s_ff ^ pd_s_ff;
      end else if (p1_ff >= p2_ff) begin
         sum_mag = MW'(p1_ff - p2_ff);
         sum_neg = p1_s_ff ^ pd_s_ff;
      end else begin
         sum_mag = MW'(p2_ff - p1_ff);
         sum_neg = !p1_s_ff ^ pd_s_ff;
      end
   end

   // binary gcd step operands; restoring divider uses gx_ff as divisor
   assign gx_sub = gx_ff - gy_ff;
   assign gy_sub = gy_ff - gx_ff;
   assign rsh    = {rem_ff[MW-2:0], dvd_ff[MW-1]};
   assign rtry   = {1'b0, rsh} - {1'b0, gx_ff};

   assign sts.err      = (sts_calc != STS_OK);
   assign sts.gcd_done = (gx_ff == '0);
   assign sts.div_done = phase_ff && (cnt_ff == CW'(MW));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= command;
         an_ff   <= a_num;
         ad_ff   <= a_den;
         bn_ff   <= b_num;
         bd_ff   <= b_den;
      end
      if (cmd.prod) begin
         ad_s_ff <= ad_ff[WIDTH-1];
         bn_s_ff <= bn_ff[WIDTH-1];
         sts_ff  <= sts_calc;
         unique case (cmd_ff)
            CMD_ADD, CMD_SUB: begin
               p1_ff <= PW'(an_m) * PW'(bd_m);
               p2_ff <= PW'(bn_m) * PW'(ad_m);
               pd_ff <= PW'(ad_m) * PW'(bd_m);
               p1_s_ff <= an_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
               p2_s_ff <= bn_ff[WIDTH-1] ^ ad_ff[WIDTH-1];
               pd_s_ff <= ad_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
            end
            CMD_MUL: begin
               p1_ff <= PW'(an_m) * PW'(bn_m);
               p2_ff <= '0;
               pd_ff <= PW'(ad_m) * PW'(bd_m);
               p1_s_ff <= an_ff[WIDTH-1] ^ bn_ff[WIDTH-1];
               p2_s_ff <= 1'b0;
               pd_s_ff <= ad_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
            end
            CMD_DIV: begin
               p1_ff <= PW'(an_m) * PW'(bd_m);
               p2_ff <= '0;
               pd_ff <= PW'(ad_m) * PW'(bn_m);
               p1_s_ff <= an_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
               p2_s_ff <= 1'b0;
               pd_s_ff <= ad_ff[WIDTH-1] ^ bn_ff[WIDTH-1];
            end
            default: begin
               p1_ff <= PW'(an_m);
               p2_ff <= '0;
               pd_ff <= PW'(ad_m);
               p1_s_ff <= an_ff[WIDTH-1];
               p2_s_ff <= 1'b0;
               pd_s_ff <= ad_ff[WIDTH-1];
            end
         endcase
      end
      if (cmd.sum) begin
         nm_ff    <= sum_mag;
         neg_ff   <= sum_neg;
         dm_ff    <= MW'(pd_ff);
         gx_ff    <= sum_mag;
         gy_ff    <= MW'(pd_ff);
         k_ff     <= '0;
         phase_ff <= 1'b0;
      end
      if (cmd.gcd_step) begin
         // strip shared and single factors of two, else halve the odd difference
         priority if (!gx_ff[0] && !gy_ff[0]) begin
            gx_ff <= gx_ff >> 1;
            gy_ff <= gy_ff >> 1;
            k_ff  <= k_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_ff <= gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_ff <= gx_sub >> 1;
         end else begin
            gy_ff <= gy_sub >> 1;
         end
      end
      if (cmd.div_start) begin
         gx_ff    <= gy_ff << k_ff;
         dvd_ff   <= nm_ff;
         rem_ff   <= '0;
         q_ff     <= '0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         if (cnt_ff == CW'(MW)) begin
            qn_ff    <= q_ff;
            dvd_ff   <= dm_ff;
            rem_ff   <= '0;
            q_ff     <= '0;
            cnt_ff   <= '0;
            phase_ff <= 1'b1;
         end else begin
            dvd_ff <= {dvd_ff[MW-2:0], 1'b0};
            if (!rtry[MW]) begin
               rem_ff <= rtry[MW-1:0];
               q_ff   <= {q_ff[MW-2:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               q_ff   <= {q_ff[MW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (cmd.out_load) begin
         rs_ff <= sts_ff;
         if (sts_ff != STS_OK) begin
            rn_ff <= '0;
            rd_ff <= '0;
         end else if (nm_ff == '0) begin
            rn_ff <= '0;
            rd_ff <= DEN_W'(1);
         end else begin
            rn_ff <= neg_ff ? NUM_W'(-qn_ff) : NUM_W'(qn_ff);
            rd_ff <= DEN_W'(q_ff);
         end
      end
   end

   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign status  = rs_ff;
endmodule

### rtl/fraction_alu_with_reduction.sv
// Top level of the fraction ALU with gcd reduction.
// channel | dir | fields
// req     | in  | tdata: command, a_num, a_den, b_num, b_den
// rsp     | out | tdata: res_num, res_den, status
// One item at a time: accept, products and sum, then the binary gcd, then two restoring
// divisions (numerator, then denominator, by the gcd), then output.
// A beat with a zero denominator or a zero divisor skips to output after the products.
// Reset clears the sequencer and output valid only.
// The result register holds while rsp_tready is low; the next result waits for it.
module fraction_alu_with_reduction
   import fau_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command, a_num, a_den, b_num, b_den from bit 0, zero pad to bytes
   input  logic [((CMD_W+4*WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_num, res_den, status from bit 0
   output logic [71:0] rsp_tdata
);
   cmd_type cmd;
   sts_type sts;
   logic [NUM_W-1:0] res_num;
   logic [DEN_W-1:0] res_den;
   logic [STS_W-1:0] status;

   fau_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   fau_dp #(.WIDTH(WIDTH)) u_dp (
      .clock,
      .command (req_tdata[CMD_W-1:0]),
      .a_num   (req_tdata[CMD_W+WIDTH-1:CMD_W]),
      .a_den   (req_tdata[CMD_W+2*WIDTH-1:CMD_W+WIDTH]),
      .b_num   (req_tdata[CMD_W+3*WIDTH-1:CMD_W+2*WIDTH]),
      .b_den   (req_tdata[CMD_W+4*WIDTH-1:CMD_W+3*WIDTH]),
      .cmd, .sts, .res_num, .res_den, .status
   );

   assign rsp_tdata = {6'd0, status, res_den, res_num};
endmodule

### sim/fraction_alu_with_reduction_tb.sv
// Self-checking testbench for the fraction ALU: directed corners, random beats, stalls.
module fraction_alu_with_reduction_tb;
   import fau_pkg::*;

   localparam int WIDTH = 16;
   localparam int REQ_W = ((CMD_W + 4*WIDTH + 7)/8)*8;
   localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd4;

   typedef struct {
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      logic [STS_W-1:0]        sts;
   } fraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   fraction_type pending_results[$];
   int error_count = 0;
   int hold_off_cycles = 0;
   bit random_ready = 1'b1;

   fraction_alu_with_reduction #(.WIDTH(WIDTH)) u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic fraction_type reduce_fraction(logic [CMD_W-1:0] cmd,
         logic signed [WIDTH-1:0] an, logic signed [WIDTH-1:0] ad,
         logic signed [WIDTH-1:0] bn, logic signed [WIDTH-1:0] bd);
      fraction_type r;
      longint n, d, x, y, t, g;
      bit uses_b;
      uses_b = (cmd <= CMD_DIV);
      r.num = '0;
      r.den = '0;
      if (ad == 0 || (uses_b && bd == 0)) begin
         r.sts = STS_ZERODEN;
         return r;
      end
      if (cmd == CMD_DIV && bn == 0) begin
         r.sts = STS_DIVZERO;
         return r;
      end
      r.sts = STS_OK;
      case (cmd)
         CMD_ADD: begin n = longint'(an)*bd + longint'(bn)*ad; d = longint'(ad)*bd; end
         CMD_SUB: begin n = longint'(an)*bd - longint'(bn)*ad; d = longint'(ad)*bd; end
         CMD_MUL: begin n = longint'(an)*bn; d = longint'(ad)*bd; end
         CMD_DIV: begin n = longint'(an)*bd; d = longint'(ad)*bn; end
         default: begin n = an; d = ad; end
      endcase
      if (n == 0) begin
         r.den = DEN_W'(1);
         return r;
      end
      x = n < 0 ? -n : n;
      y = d < 0 ? -d : d;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      g = x;
      if (d < 0) n = -n;
      r.num = NUM_W'(n / g);
      r.den = DEN_W'((d < 0 ? -d : d) / g);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_fraction_op(logic [CMD_W-1:0] cmd, int an, int ad, int bn, int bd,
         bit no_gap = 1'b0);
      int gap;
      logic [WIDTH-1:0] an_v, ad_v, bn_v, bd_v;
      an_v = WIDTH'(an);
      ad_v = WIDTH'(ad);
      bn_v = WIDTH'(bn);
      bd_v = WIDTH'(bd);
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({bd_v, bn_v, ad_v, an_v, cmd});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(reduce_fraction(cmd, an_v, ad_v, bn_v, bd_v));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() > 0) @(negedge clock);
      @(negedge clock);
   endtask

   // rsp side: random stalls, with an optional long hold-off
   initial begin
      int wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (!random_ready) begin
            rsp_tready <= 1'b1;
         end else begin
            wait_cycles = $urandom_range(0, 7);
            if (wait_cycles == 0 || !rsp_tready) rsp_tready <= 1'b1;
            if (wait_cycles > 0 && rsp_tready) begin
               rsp_tready <= 1'b0;
               repeat (wait_cycles - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      fraction_type want;
      logic signed [NUM_W-1:0] got_num;
      logic [DEN_W-1:0] got_den;
      logic [STS_W-1:0] got_sts;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_num = rsp_tdata[NUM_W-1:0];
            got_den = rsp_tdata[NUM_W+DEN_W-1:NUM_W];
            got_sts = rsp_tdata[NUM_W+DEN_W+STS_W-1:NUM_W+DEN_W];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (got_num !== want.num) report_mismatch("res_num", got_num, want.num);
               if (got_den !== want.den) report_mismatch("res_den", got_den, want.den);
               if (got_sts !== want.sts) report_mismatch("status", got_sts, want.sts);
            end
         end
      end
   end

   task automatic test_directed();
      logic [WIDTH-1:0] mn, mx;
      mn = 16'h8000;
      mx = 16'h7fff;
      send_fraction_op(CMD_ADD, 1, 2, 1, 3);
      send_fraction_op(CMD_SUB, 1, 2, 1, 2);
      send_fraction_op(CMD_MUL, mn, mx, mn, 1);
      send_fraction_op(CMD_DIV, mn, 1, 1, mn);
      send_fraction_op(CMD_REDUCE, 6, -4, 0, 0);
      send_fraction_op(CMD_ADD, mn, mn, mn, mn);
      send_fraction_op(CMD_SUB, mx, mn, mn, mx);
      send_fraction_op(CMD_MUL, mx, mx, mx, mx);
      send_fraction_op(CMD_DIV, mn, mx, mx, mn);
      send_fraction_op(CMD_ADD, 3, 0, 1, 1);
      send_fraction_op(CMD_SUB, 3, 5, 1, 0);
      send_fraction_op(CMD_DIV, 3, 5, 0, 7);
      send_fraction_op(CMD_DIV, 3, 0, 0, 7);
      send_fraction_op(CMD_REDUCE, 0, -7, 0, 0);
      send_fraction_op(CMD_REDUCE, 5, 0, 0, 0);
      send_fraction_op(CMD_REDUCE, 5, 3, 9, 0);
      send_fraction_op(3'd5, 10, -20, 0, 0);
      send_fraction_op(3'd6, mn, mn, 1, 1);
      send_fraction_op(3'd7, -9, 12, 3, 0);
      send_fraction_op(CMD_MUL, 0, -3, 5, 7);
      send_fraction_op(CMD_ADD, -1, 1, 1, 1);
   endtask

   function automatic logic [WIDTH-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return WIDTH'(int'($urandom_range(0, 7)) - 3);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         2: return WIDTH'(int'($urandom_range(1, 40)) * ($urandom_range(0, 1) ? 1 : -1));
         default: return WIDTH'($urandom);
      endcase
   endfunction

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_fraction_op(CMD_W'($urandom_range(0, 7)), pick_value(), pick_value(),
            pick_value(), pick_value());
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 400;
      for (int i = 0; i < 8; i++) begin
         send_fraction_op(CMD_W'($urandom_range(0, 4)), pick_value(), pick_value(),
            pick_value(), pick_value(), 1'b1);
      end
      drain_results();
   endtask

   task automatic test_no_stall();
      random_ready = 1'b0;
      for (int i = 0; i < 40; i++) begin
         send_fraction_op(CMD_W'($urandom_range(0, 7)), WIDTH'($urandom), WIDTH'($urandom),
            WIDTH'($urandom), WIDTH'($urandom), 1'b1);
      end
      drain_results();
      random_ready = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain_results();
      test_backpressure();
      test_no_stall();
      test_random(480);
      drain_results();
      repeat (300) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("fraction_alu_with_reduction_tb: clean");
      end else begin
         $display("fraction_alu_with_reduction_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("fraction_alu_with_reduction_tb: errors");
      $finish;
   end
endmodule
